FILE: rtl/core/vcc_pkg.sv
package vcc_pkg;

  // machine shape
  localparam int COIN_KINDS  = 3;
  localparam int DRINK_KINDS = 4;
  localparam int KIND_W      = 2;   // coin kind select width

  // field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CREDIT_W = 16;
  localparam int STOCK_W  = 8;
  localparam int PRICE_W  = 14;
  localparam int VALUE_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // operations
  localparam logic [OP_W-1:0] OP_COIN   = 2'd0;
  localparam logic [OP_W-1:0] OP_DOLLAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BUY    = 2'd2;
  localparam logic [OP_W-1:0] OP_RETURN = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CREDIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_STOCK  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_C = 3'd6;

  localparam logic [CREDIT_W-1:0] DOLLAR_CENTS = 16'd100;
  localparam logic [STOCK_W-1:0]  STOCK_MAX    = 8'd255;
  localparam logic [STOCK_W-1:0]  DRINK_STOCK_RST = 8'd5;

  localparam logic [PRICE_W-1:0] PRICE_RST [DRINK_KINDS] =
    '{14'd75, 14'd75, 14'd80, 14'd80};
  localparam logic [VALUE_W-1:0] VALUE_RST [COIN_KINDS] =
    '{10'd25, 10'd10, 10'd5};
  localparam logic [STOCK_W-1:0] COIN_STOCK_RST [COIN_KINDS] =
    '{8'd5, 8'd5, 8'd20};

  localparam logic [KIND_W-1:0] LAST_KIND = KIND_W'(COIN_KINDS - 1);

  typedef struct packed {
    logic do_op;      // execute insert / dollar / buy from the input word
    logic start_pay;  // begin coin return
    logic pay_step;   // one change step
    logic load_out;   // move result into the output register
  } vcc_cmd_t;

  typedef struct packed {
    logic pay_done;   // last coin kind finished this cycle
  } vcc_sts_t;

endpackage

FILE: rtl/core/vcc_if.sv
interface vcc_in_if
  import vcc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] item_index;

  modport source (output valid, output operation, output item_index, input ready);
  modport sink   (input valid, input operation, input item_index, output ready);
endinterface

interface vcc_out_if
  import vcc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CREDIT_W-1:0] credit_after;
  logic [STOCK_W-1:0]  returned_kind_a;
  logic [STOCK_W-1:0]  returned_kind_b;
  logic [STOCK_W-1:0]  returned_kind_c;

  modport source (output valid, output status, output credit_after,
                  output returned_kind_a, output returned_kind_b,
                  output returned_kind_c, input ready);
  modport sink   (input valid, input status, input credit_after,
                  input returned_kind_a, input returned_kind_b,
                  input returned_kind_c, output ready);
endinterface

FILE: rtl/core/vcc_ctrl.sv
module vcc_ctrl
  import vcc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_operation,
  output logic            out_valid,
  input  logic            out_ready,
  output vcc_cmd_t        cmd,
  input  vcc_sts_t        sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAY  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // commands use state, handshakes and opcode only, never datapath status
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_RETURN) cmd.start_pay = 1'b1;
          else cmd.do_op = 1'b1;
        end
      end
      S_PAY: cmd.pay_step = 1'b1;
      // output register free or draining this cycle
      S_FIN: cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = (in_operation == OP_RETURN) ? S_PAY : S_FIN;
      end
      S_PAY: begin
        if (sts.pay_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (cmd.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/vcc_dp.sv
module vcc_dp
  import vcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IDX_W-1:0]      in_item_index,
  input  vcc_cmd_t              cmd,
  output vcc_sts_t              sts,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CREDIT_W-1:0]   out_credit_after,
  output logic [STOCK_W-1:0]    out_returned_kind_a,
  output logic [STOCK_W-1:0]    out_returned_kind_b,
  output logic [STOCK_W-1:0]    out_returned_kind_c
);

  logic [PRICE_W-1:0]  price       [DRINK_KINDS];
  logic [VALUE_W-1:0]  coin_value  [COIN_KINDS];
  logic [STOCK_W-1:0]  drink_stock [DRINK_KINDS];
  logic [STOCK_W-1:0]  coin_stock  [COIN_KINDS];
  logic [STOCK_W-1:0]  paid        [COIN_KINDS];
  logic [CREDIT_W-1:0] credit;
  logic [KIND_W-1:0]   kind;
  logic [STATUS_W-1:0] res_status;

  // one shared coin-array address: input kind on insert, counter on return
  logic [KIND_W-1:0]   coin_addr;
  logic [STOCK_W-1:0]  cs;
  logic [VALUE_W-1:0]  cv;
  logic                coin_ok;
  logic [CREDIT_W-1:0] add_val;
  logic [CREDIT_W:0]   sum;
  logic [CREDIT_W-1:0] credit_sat;
  logic [PRICE_W-1:0]  pr;
  logic [STOCK_W-1:0]  ds;
  logic                pay_coin;
  logic                pay_all;
  logic                advance;

  assign coin_addr = cmd.pay_step ? kind : in_item_index;
  assign coin_ok   = 32'(coin_addr) < COIN_KINDS;
  assign cs        = coin_ok ? coin_stock[coin_addr] : '0;
  assign cv        = coin_ok ? coin_value[coin_addr] : '0;
  assign pr        = price[in_item_index];
  assign ds        = drink_stock[in_item_index];

  assign add_val    = (in_operation == OP_DOLLAR) ? DOLLAR_CENTS : CREDIT_W'(cv);
  assign sum        = {1'b0, credit} + {1'b0, add_val};
  assign credit_sat = sum[CREDIT_W] ? '1 : sum[CREDIT_W-1:0];

  // change step: zero-valued kind empties its stock at once
  assign pay_all  = (cv == '0);
  assign pay_coin = !pay_all && (cs != '0) && (credit >= CREDIT_W'(cv));
  assign advance  = !pay_coin;
  assign sts.pay_done = cmd.pay_step && advance && (kind == LAST_KIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      kind   <= '0;
      for (int i = 0; i < DRINK_KINDS; i++) begin
        price[i]       <= PRICE_RST[i];
        drink_stock[i] <= DRINK_STOCK_RST;
      end
      for (int i = 0; i < COIN_KINDS; i++) begin
        coin_value[i] <= VALUE_RST[i];
        coin_stock[i] <= COIN_STOCK_RST[i];
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRICE_A: price[0] <= cfg_data[PRICE_W-1:0];
          REG_PRICE_B: price[1] <= cfg_data[PRICE_W-1:0];
          REG_PRICE_C: price[2] <= cfg_data[PRICE_W-1:0];
          REG_PRICE_D: price[3] <= cfg_data[PRICE_W-1:0];
          REG_VALUE_A: coin_value[0] <= cfg_data[VALUE_W-1:0];
          REG_VALUE_B: coin_value[1] <= cfg_data[VALUE_W-1:0];
          REG_VALUE_C: coin_value[2] <= cfg_data[VALUE_W-1:0];
          default: ;
        endcase
      end

      if (cmd.do_op) begin
        unique case (in_operation)
          OP_COIN: begin
            if (coin_ok) begin
              if (cs != STOCK_MAX) coin_stock[coin_addr] <= cs + 8'd1;
              credit <= credit_sat;
            end
          end
          OP_DOLLAR: credit <= credit_sat;
          OP_BUY: begin
            if (credit >= CREDIT_W'(pr) && ds != '0) begin
              drink_stock[in_item_index] <= ds - 8'd1;
              credit <= credit - CREDIT_W'(pr);
            end
          end
          default: ;
        endcase
      end

      if (cmd.start_pay) kind <= '0;

      if (cmd.pay_step) begin
        if (pay_all) begin
          coin_stock[kind] <= '0;
        end else if (pay_coin) begin
          coin_stock[kind] <= cs - 8'd1;
          credit <= credit - CREDIT_W'(cv);
        end
        if (advance) kind <= kind + 1'b1;
        if (sts.pay_done) credit <= '0;
      end
    end
  end

  // result staging and output register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.do_op) begin
      for (int i = 0; i < COIN_KINDS; i++) paid[i] <= '0;
      unique case (in_operation)
        OP_COIN:   res_status <= coin_ok ? ST_OK : ST_BAD_INDEX;
        OP_BUY: begin
          if (32'(in_item_index) >= DRINK_KINDS) res_status <= ST_BAD_INDEX;
          else if (credit < CREDIT_W'(pr))       res_status <= ST_NO_CREDIT;
          else if (ds == '0)                     res_status <= ST_NO_STOCK;
          else                                   res_status <= ST_OK;
        end
        default:   res_status <= ST_OK;
      endcase
    end
    if (cmd.start_pay) begin
      for (int i = 0; i < COIN_KINDS; i++) paid[i] <= '0;
      res_status <= ST_OK;
    end
    if (cmd.pay_step) begin
      if (pay_all)       paid[kind] <= cs;
      else if (pay_coin) paid[kind] <= paid[kind] + 8'd1;
    end
    if (cmd.load_out) begin
      out_status          <= res_status;
      out_credit_after    <= credit;
      out_returned_kind_a <= paid[0];
      out_returned_kind_b <= paid[1];
      out_returned_kind_c <= paid[2];
    end
  end

endmodule

FILE: rtl/core/vending_credit_and_change.sv
// Insert, dollar and buy execute at acceptance; fin loads the result once the
//   output register can take it. A return first adds one change step per coin
//   paid plus one per kind (a zero-valued kind pays its whole stock in one step).
// Throughput: one word in flight; the next is accepted once the result is loaded.
// Reset (rst, synchronous): credit 0, drink stock 5 each, coin stock 5/5/20,
//   prices 75/75/80/80, coin values 25/10/5, no result pending.
module vending_credit_and_change
  import vcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // event words in, result words out
  vcc_in_if.sink                in_ch,
  vcc_out_if.source             out_ch
);

  vcc_cmd_t cmd;
  vcc_sts_t sts;

  // Controller: sequences one event word at a time.
  //   idle -> fin        insert / dollar / buy, executed at acceptance
  //   idle -> pay -> fin coin return, greedy change kind by kind
  //   fin  -> idle       result copied into the output register
  // The output register decouples the sides: a new word is accepted
  // while the previous result still waits for the sink.
  vcc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_operation (in_ch.operation),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Datapath: config registers, credit and stock counters, change unit
  // (compare credit against coin value, subtract, count), result staging.
  // Credit saturates at all ones on coin or dollar; coin stock saturates at 255.
  vcc_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_operation        (in_ch.operation),
    .in_item_index       (in_ch.item_index),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (out_ch.status),
    .out_credit_after    (out_ch.credit_after),
    .out_returned_kind_a (out_ch.returned_kind_a),
    .out_returned_kind_b (out_ch.returned_kind_b),
    .out_returned_kind_c (out_ch.returned_kind_c)
  );

endmodule

FILE: rtl/core/vcc_checker.sv
module vcc_checker
  import vcc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [CREDIT_W-1:0] credit_after,
  input logic [STOCK_W-1:0]  ret_a,
  input logic [STOCK_W-1:0]  ret_b,
  input logic [STOCK_W-1:0]  ret_c
);

  // result word held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // one event in flight: input closes right after acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // coins paid out only on a return, which leaves no credit
  a_paid_zero_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ret_a != '0 || ret_b != '0 || ret_c != '0) |->
      credit_after == '0 && status == ST_OK)
    else $error("payout with credit left or bad status");

  // failed events pay nothing
  a_fail_no_pay: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> ret_a == '0 && ret_b == '0 && ret_c == '0)
    else $error("payout on failed event");

endmodule

bind vending_credit_and_change vcc_checker u_vcc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .credit_after (out_ch.credit_after),
  .ret_a        (out_ch.returned_kind_a),
  .ret_b        (out_ch.returned_kind_b),
  .ret_c        (out_ch.returned_kind_c)
);

FILE: sim/vending_credit_and_change_tb.sv
module vending_credit_and_change_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcc_pkg::*;

  // Run limits. The slowest legal run is ~700 words, each with a worst-case
  // change payout plus stalls; the cap is several times that.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned CREDIT_CEIL = (1 << CREDIT_W) - 1;

  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Coin kind select with no coin behind it.
  localparam logic [IDX_W-1:0] BAD_COIN_KIND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CREDIT_W-1:0] credit;
    logic [STOCK_W-1:0]  paid_a;
    logic [STOCK_W-1:0]  paid_b;
    logic [STOCK_W-1:0]  paid_c;
  } vend_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vcc_in_if  in_ch ();
  vcc_out_if out_ch ();

  vending_credit_and_change uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Machine model: credit, stocks and the register file, updated per accepted
  // word in acceptance order.
  // ---------------------------------------------------------------------------
  int unsigned        credit_bal;
  logic [STOCK_W-1:0] drink_cnt [DRINK_KINDS];
  logic [STOCK_W-1:0] coin_cnt  [COIN_KINDS];
  logic [PRICE_W-1:0] price_tab [DRINK_KINDS];
  logic [VALUE_W-1:0] coin_val  [COIN_KINDS];

  vend_result_t pending_results [$];

  int  words_sent     = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  send_idle_pct  = 0;
  int  stall_pct      = 0;
  logic out_hold      = 1'b0;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void reset_model();
    credit_bal = 0;
    for (int s = 0; s < DRINK_KINDS; s++) begin
      drink_cnt[s] = DRINK_STOCK_RST;
      price_tab[s] = PRICE_RST[s];
    end
    for (int k = 0; k < COIN_KINDS; k++) begin
      coin_cnt[k] = COIN_STOCK_RST[k];
      coin_val[k] = VALUE_RST[k];
    end
  endfunction

  // credit pins at the top of its range
  function automatic void add_credit(input int unsigned cents);
    credit_bal = (credit_bal + cents > CREDIT_CEIL) ? CREDIT_CEIL : credit_bal + cents;
  endfunction

  function automatic vend_result_t apply_event(input logic [OP_W-1:0]  op,
                                               input logic [IDX_W-1:0] idx);
    vend_result_t res;
    int unsigned  paid [COIN_KINDS];
    int unsigned  n;
    res = '0;
    foreach (paid[k]) paid[k] = 0;
    case (op)
      OP_COIN: begin
        if (int'(idx) >= COIN_KINDS) begin
          res.status = ST_BAD_INDEX;
        end else begin
          // stock sticks at 255, value is still credited
          if (coin_cnt[idx] != STOCK_MAX) coin_cnt[idx] = coin_cnt[idx] + 1'b1;
          add_credit(coin_val[idx]);
        end
      end
      OP_DOLLAR: add_credit(DOLLAR_CENTS);
      OP_BUY: begin
        // short credit wins over an empty slot; a failed buy touches nothing
        if (int'(idx) >= DRINK_KINDS) res.status = ST_BAD_INDEX;
        else if (credit_bal < price_tab[idx]) res.status = ST_NO_CREDIT;
        else if (drink_cnt[idx] == '0) res.status = ST_NO_STOCK;
        else begin
          drink_cnt[idx] = drink_cnt[idx] - 1'b1;
          credit_bal     = credit_bal - price_tab[idx];
        end
      end
      OP_RETURN: begin
        // greedy from kind 0; a zero-valued kind empties its whole stock
        for (int k = 0; k < COIN_KINDS; k++) begin
          n = coin_cnt[k];
          if (coin_val[k] != '0 && credit_bal / coin_val[k] < n) n = credit_bal / coin_val[k];
          coin_cnt[k] = coin_cnt[k] - n[STOCK_W-1:0];
          credit_bal  = credit_bal - n * coin_val[k];
          paid[k]     = n;
        end
        // whatever could not be paid is kept by the machine
        credit_bal = 0;
      end
    endcase
    res.credit = credit_bal[CREDIT_W-1:0];
    res.paid_a = paid[0][STOCK_W-1:0];
    res.paid_b = paid[1][STOCK_W-1:0];
    res.paid_c = paid[2][STOCK_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One register write: enable high for one edge, then lowered again.
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PRICE_A, REG_PRICE_B, REG_PRICE_C, REG_PRICE_D:
        price_tab[idx - REG_PRICE_A] = data[PRICE_W-1:0];
      REG_VALUE_A, REG_VALUE_B, REG_VALUE_C:
        coin_val[idx - REG_VALUE_A] = data[VALUE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one event word; valid stays up into the next word unless the sender
  // idles, so it is never lowered and raised in the same step.
  task automatic send_word(input logic [OP_W-1:0]  op,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.item_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_event(op, idx));
    words_sent++;
  endtask

  // Sender goes quiet until every outstanding result word is back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct    <= receiver_pct;
  endtask

  // Mostly customer sessions (coins in, up to two buys, usually change out), the
  // rest raw noise words.
  task automatic run_random_words(input int count);
    int stop_at;
    int n_ins;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        send_word(OP_W'($urandom), IDX_W'($urandom));
      end else begin
        n_ins = $urandom_range(1, 8);
        repeat (n_ins) begin
          if ($urandom_range(4) == 0) send_word(OP_DOLLAR, IDX_W'($urandom));
          else send_word(OP_COIN, ($urandom_range(15) == 0) ? BAD_COIN_KIND
                                                           : IDX_W'($urandom_range(2)));
        end
        repeat ($urandom_range(2)) send_word(OP_BUY, IDX_W'($urandom));
        if ($urandom_range(4) != 0) send_word(OP_RETURN, IDX_W'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, or held off entirely while out_hold is set.
  always @(posedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    vend_result_t seen;
    vend_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.status = out_ch.status;
      seen.credit = out_ch.credit_after;
      seen.paid_a = out_ch.returned_kind_a;
      seen.paid_b = out_ch.returned_kind_b;
      seen.paid_c = out_ch.returned_kind_c;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("cycle %0d: unexpected result word status %0d credit %0d paid %0d/%0d/%0d",
                   cycle_count, seen.status, seen.credit, seen.paid_a, seen.paid_b,
                   seen.paid_c);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d: expected status %0d credit %0d paid %0d/%0d/%0d,",
                     cycle_count, want.status, want.credit, want.paid_a, want.paid_b,
                     want.paid_c,
                     " got status %0d credit %0d paid %0d/%0d/%0d",
                     seen.status, seen.credit, seen.paid_a, seen.paid_b, seen.paid_c);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: empty return, short credit, bad coin kind, every insert,
  // draining a slot, empty slot with credit, and empty slot without credit.
  task automatic test_basic_events();
    set_idling(0, 0);
    send_word(OP_RETURN, 2'd0);       // nothing owed, nothing paid
    send_word(OP_BUY, 2'd0);          // zero credit
    send_word(OP_COIN, BAD_COIN_KIND);
    send_word(OP_COIN, 2'd0);
    send_word(OP_COIN, 2'd1);
    send_word(OP_COIN, 2'd2);
    send_word(OP_DOLLAR, 2'd3);       // index is don't-care here
    send_word(OP_BUY, 2'd3);
    send_word(OP_BUY, 2'd0);          // left with less than the price
    repeat (4) send_word(OP_DOLLAR, 2'd0);
    repeat (5) send_word(OP_BUY, 2'd1);  // slot 1 runs dry
    send_word(OP_BUY, 2'd1);          // credit there, stock not
    send_word(OP_RETURN, 2'd2);
    send_word(OP_BUY, 2'd1);          // both checks fail: credit reported
  endtask

  // Registers at or near the edges of their ranges, a masked value, a
  // dead index, and a zero coin value on return.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_PRICE_A, 14'd0);
    write_reg(REG_PRICE_B, 14'h3FFF);
    write_reg(REG_PRICE_C, 14'd10000);
    write_reg(REG_PRICE_D, 14'd1);
    write_reg(REG_VALUE_A, 14'h3FFF);  // top bits dropped, 1023 left
    write_reg(REG_VALUE_B, 14'd1);
    write_reg(REG_VALUE_C, 14'd0);
    write_reg(REG_UNUSED, 14'h2A5A);
    send_word(OP_BUY, 2'd0);          // free drink with no credit
    send_word(OP_BUY, 2'd1);
    repeat (2) send_word(OP_DOLLAR, 2'd1);
    send_word(OP_BUY, 2'd3);
    send_word(OP_COIN, 2'd0);
    send_word(OP_COIN, 2'd1);
    send_word(OP_COIN, 2'd2);         // worthless coin, stock still grows
    send_word(OP_BUY, 2'd2);
    send_word(OP_RETURN, 2'd0);       // kind c stock paid out whole
    send_word(OP_RETURN, 2'd1);
    wait_drained();
    for (int r = 0; r < DRINK_KINDS; r++)
      write_reg(REG_PRICE_A + r[CFG_IDX_W-1:0], CFG_DATA_W'(PRICE_RST[r]));
    for (int r = 0; r < COIN_KINDS; r++)
      write_reg(REG_VALUE_A + r[CFG_IDX_W-1:0], CFG_DATA_W'(VALUE_RST[r]));
  endtask

  // Big coins until the credit pins at its ceiling and kind c stock sits at
  // 255, then change out of a full hopper.
  task automatic test_credit_and_stock_ceiling();
    wait_drained();
    write_reg(REG_VALUE_C, 14'd1000);
    repeat (260) send_word(OP_COIN, 2'd2);
    send_word(OP_DOLLAR, 2'd0);
    send_word(OP_RETURN, 2'd3);
    send_word(OP_RETURN, 2'd0);
    wait_drained();
    write_reg(REG_VALUE_C, CFG_DATA_W'(VALUE_RST[2]));
  endtask

  // Four phases, each with fresh prices and coin values (one at the extremes)
  // and its own idling mix.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] data;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      for (int r = int'(REG_PRICE_A); r <= int'(REG_VALUE_C); r++) begin
        if (r <= int'(REG_PRICE_D))
          data = (phase == 2) ? (r[0] ? 14'd10000 : 14'd0)
                              : CFG_DATA_W'($urandom_range(20, 250));
        else
          data = (phase == 2) ? ((r == int'(REG_VALUE_B)) ? 14'd1 : 14'd1000)
                              : CFG_DATA_W'($urandom_range(1, 60));
        write_reg(r[CFG_IDX_W-1:0], data);
      end
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(61, 0);
        2: set_idling(0, 61);
        default: set_idling(35, 35);
      endcase
      run_random_words(65);
    end
  endtask

  // Receiver shuts off for a long stretch while words keep coming, so the
  // block backs up into its input; a full drain and an idling run follow.
  task automatic test_output_backpressure();
    wait_drained();
    set_idling(0, 0);
    fork
      begin
        out_hold <= 1'b1;
        repeat (400) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    run_random_words(30);
    wait_drained();
    set_idling(35, 35);
    run_random_words(20);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = '0;
    in_ch.item_index = '0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_events();
    test_register_extremes();
    test_credit_and_stock_ceiling();
    test_random_traffic();
    test_output_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
